// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level; they use the clk and rst_n of the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bva_pkg.sv =====
// Shared constants and types of the battery voltage averager.
package bva_pkg;

  localparam int ADC_W      = 9;
  localparam int VOLT_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int PRESS_W    = 8;
  localparam int Q_FRAC     = 8;
  localparam int PROD_W     = SCALE_W + ADC_W;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int WINDOW_DEF = 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(256);
  localparam logic [ADC_W-1:0]   THRESH_RESET = ADC_W'(100);
  localparam logic [PRESS_W-1:0] PRESS_MAX    = '1;
  localparam logic [VOLT_W-1:0]  VOLT_MAX     = '1;

  // register index, taken from paddr[2]
  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/bva_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module bva_div #(
  parameter int DVD_W = 12,
  parameter int DVS_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output logic [DVD_W-1:0]    quotient,
  output bva_pkg::div_stat_t  stat
);
  import bva_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, q_r[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== hw/rtl/bva_ring.sv =====
// History ring memory with per-entry valid bits; invalid entries read as zero.
module bva_ring #(
  parameter int DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [bva_pkg::ADC_W-1:0]   wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [bva_pkg::ADC_W-1:0]   rd_data
);
  import bva_pkg::*;

  logic [ADC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [ADC_W-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hw/rtl/battery_voltage_averager.sv =====
// Battery voltage averager: top level with poll sequencer, ring walk and gain stage.
// Throughput: the first WINDOW-1 readings of a poll are taken one per cycle; the last one
//   holds input off until the result goes to the output register, through the ring walk
//   and the serial mean divide; a press poll skips both, an empty ring skips the divide.
// Result word: valid once that sequence ends and the output register is free.
// Reset: rst_n synchronous, active low; empties ring, clears counters and stored means, presets cfg registers.
`include "assert_macros.svh"

module battery_voltage_averager #(
  parameter int WINDOW = bva_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input word channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bva_pkg::ADC_W-1:0]     in_adc_reading,
  // result word channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bva_pkg::VOLT_W-1:0]    out_voltage_mv,
  output logic [bva_pkg::ADC_W-1:0]     out_pin_mean,
  output logic [bva_pkg::ADC_W-1:0]     out_poll_average,
  output logic [bva_pkg::PRESS_W-1:0]   out_press_count,
  output logic                          out_button_held,
  output logic                          out_is_press,
  // configuration port (APB-style)
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bva_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [bva_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [bva_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import bva_pkg::*;

  // IDX_W indexes the ring and counts readings within a poll.
  // SUM_W holds up to 511*WINDOW; CNT_W holds the count WINDOW itself.
  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = ADC_W + IDX_W;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0] WIN_LAST = IDX_W'(WINDOW - 1);

  // poll average = sum / WINDOW as a reciprocal multiply:
  // ceil(2^(SUM_W+IDX_W) / WINDOW) is exact for every SUM_W-bit sum
  localparam int     RCP_SH = SUM_W + IDX_W;
  localparam int     RCP_W  = SUM_W + 1;
  localparam int     AP_W   = SUM_W + RCP_W;
  localparam longint RCP_L  = ((longint'(1) << RCP_SH) + longint'(WINDOW) - 1) /
                              longint'(WINDOW);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

  typedef enum logic [2:0] {
    S_IDLE,   // take readings, accumulate burst sum
    S_AVG,    // reciprocal multiply forms poll average; press decision
    S_WALK,   // read ring one entry a cycle
    S_WSUM,   // fold in last ring entry, start mean divide unless ring is empty
    S_MEAN,   // divider forms ring mean; multiply by gain
    S_SAT,    // shift and saturate product
    S_OUT     // hand result to output register
  } state_t;

  state_t              state_r, state_nxt;
  logic [SUM_W-1:0]    burst_sum_r, burst_sum_nxt;
  logic [IDX_W-1:0]    burst_cnt_r, burst_cnt_nxt;
  logic [IDX_W-1:0]    ring_pos_r, ring_pos_nxt;
  logic [IDX_W-1:0]    walk_idx_r, walk_idx_nxt;
  logic [PRESS_W-1:0]  press_r, press_nxt;
  logic [VOLT_W-1:0]   stored_volt_r, stored_volt_nxt;
  logic [ADC_W-1:0]    stored_mean_r, stored_mean_nxt;
  logic [ADC_W-1:0]    avg_r, avg_nxt;
  logic                is_press_r, is_press_nxt;
  logic                empty_r, empty_nxt;
  logic                acc_pend_r;
  logic [SUM_W-1:0]    tot_r, tot_nxt;
  logic [CNT_W-1:0]    vcnt_r, vcnt_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;
  logic [ADC_W-1:0]    thresh_r, thresh_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VOLT_W-1:0]   out_volt_r, out_volt_nxt;
  logic [ADC_W-1:0]    out_mean_r, out_mean_nxt;
  logic [ADC_W-1:0]    out_avg_r, out_avg_nxt;
  logic [PRESS_W-1:0]  out_press_r, out_press_nxt;
  logic                out_held_r, out_held_nxt;
  logic                out_isp_r, out_isp_nxt;

  // ring mean divider
  logic                div_start;
  logic [SUM_W-1:0]    div_dvd;
  logic [CNT_W-1:0]    div_dvs;
  logic [SUM_W-1:0]    div_q;
  div_stat_t           div_stat;

  // ring
  logic                ring_wr_en;
  logic                ring_rd_en;
  logic [ADC_W-1:0]    ring_rd_data;

  logic                in_acc;
  logic                cfg_wr;
  logic [SUM_W-1:0]    sum_add;
  logic [SUM_W-1:0]    tot_fin;
  logic [CNT_W-1:0]    vcnt_fin;
  logic [ADC_W-1:0]    q_lo;
  logic [PROD_W-Q_FRAC-1:0] prod_sh;
  logic [AP_W-1:0]     avg_prod;
  logic [ADC_W-1:0]    avg_calc;

  bva_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_stat)
  );

  bva_ring #(
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ring_wr_en),
    .wr_addr (ring_pos_r),
    .wr_data (avg_nxt),
    .rd_en   (ring_rd_en),
    .rd_addr (walk_idx_r),
    .rd_data (ring_rd_data)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign ring_rd_en = (state_r == S_WALK);

  assign sum_add  = burst_sum_r + SUM_W'(in_adc_reading);
  assign q_lo     = div_q[ADC_W-1:0];
  assign prod_sh  = prod_r[PROD_W-1:Q_FRAC];
  // full poll sum sits in burst_sum_r while in S_AVG
  assign avg_prod = AP_W'(burst_sum_r) * AP_W'(RCP);
  assign avg_calc = avg_prod[RCP_SH +: ADC_W];

  // ring walk accumulator: zero entries are empty
  always_comb begin
    tot_fin  = tot_r;
    vcnt_fin = vcnt_r;
    if (acc_pend_r && (ring_rd_data != '0)) begin
      tot_fin  = tot_r + SUM_W'(ring_rd_data);
      vcnt_fin = vcnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      REG_SCALE:  cfg_prdata = CFG_DW'(scale_r);
      REG_THRESH: cfg_prdata = CFG_DW'(thresh_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    burst_sum_nxt   = burst_sum_r;
    burst_cnt_nxt   = burst_cnt_r;
    ring_pos_nxt    = ring_pos_r;
    walk_idx_nxt    = walk_idx_r;
    press_nxt       = press_r;
    stored_volt_nxt = stored_volt_r;
    stored_mean_nxt = stored_mean_r;
    avg_nxt         = avg_r;
    is_press_nxt    = is_press_r;
    empty_nxt       = empty_r;
    tot_nxt         = tot_r;
    vcnt_nxt        = vcnt_r;
    prod_nxt        = prod_r;
    scale_nxt       = scale_r;
    thresh_nxt      = thresh_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_volt_nxt    = out_volt_r;
    out_mean_nxt    = out_mean_r;
    out_avg_nxt     = out_avg_r;
    out_press_nxt   = out_press_r;
    out_held_nxt    = out_held_r;
    out_isp_nxt     = out_isp_r;
    div_start       = 1'b0;
    div_dvd         = tot_fin;
    div_dvs         = vcnt_fin;
    ring_wr_en      = 1'b0;

    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SCALE:  scale_nxt  = cfg_pwdata[SCALE_W-1:0];
        REG_THRESH: thresh_nxt = cfg_pwdata[ADC_W-1:0];
        default:    scale_nxt  = scale_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (burst_cnt_r == WIN_LAST) begin
            // poll complete: keep the full sum for the average
            burst_sum_nxt = sum_add;
            burst_cnt_nxt = '0;
            state_nxt     = S_AVG;
          end else begin
            burst_sum_nxt = sum_add;
            burst_cnt_nxt = burst_cnt_r + IDX_W'(1);
          end
        end
      end
      S_AVG: begin
        avg_nxt       = avg_calc;
        burst_sum_nxt = '0;
        if (avg_calc < thresh_r) begin
          // button press: stored means are reported as they are
          is_press_nxt = 1'b1;
          empty_nxt    = 1'b0;
          if (press_r != PRESS_MAX) begin
            press_nxt = press_r + PRESS_W'(1);
          end
          state_nxt = S_OUT;
        end else begin
          is_press_nxt = 1'b0;
          press_nxt    = '0;
          ring_wr_en   = 1'b1;
          ring_pos_nxt = (ring_pos_r == WIN_LAST) ? '0 : ring_pos_r + IDX_W'(1);
          walk_idx_nxt = '0;
          tot_nxt      = '0;
          vcnt_nxt     = '0;
          state_nxt    = S_WALK;
        end
      end
      S_WALK: begin
        tot_nxt  = tot_fin;
        vcnt_nxt = vcnt_fin;
        if (walk_idx_r == WIN_LAST) begin
          state_nxt = S_WSUM;
        end else begin
          walk_idx_nxt = walk_idx_r + IDX_W'(1);
        end
      end
      S_WSUM: begin
        tot_nxt  = tot_fin;
        vcnt_nxt = vcnt_fin;
        div_dvd  = tot_fin;
        div_dvs  = vcnt_fin;
        if (vcnt_fin != '0) begin
          div_start = 1'b1;
          empty_nxt = 1'b0;
          state_nxt = S_MEAN;
        end else begin
          // empty ring: report 0 mV, keep stored means
          empty_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_MEAN: begin
        if (div_stat.done) begin
          stored_mean_nxt = q_lo;
          prod_nxt        = PROD_W'(scale_r) * PROD_W'(q_lo);
          state_nxt       = S_SAT;
        end
      end
      S_SAT: begin
        stored_volt_nxt = (prod_sh > (PROD_W - Q_FRAC)'(VOLT_MAX)) ? VOLT_MAX :
                          prod_sh[VOLT_W-1:0];
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_volt_nxt  = empty_r ? '0 : stored_volt_r;
          out_mean_nxt  = stored_mean_r;
          out_avg_nxt   = avg_r;
          out_press_nxt = press_r;
          out_held_nxt  = (press_r > PRESS_W'(1));
          out_isp_nxt   = is_press_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      burst_sum_r   <= '0;
      burst_cnt_r   <= '0;
      ring_pos_r    <= '0;
      walk_idx_r    <= '0;
      press_r       <= '0;
      stored_volt_r <= '0;
      stored_mean_r <= '0;
      avg_r         <= '0;
      is_press_r    <= 1'b0;
      empty_r       <= 1'b0;
      acc_pend_r    <= 1'b0;
      tot_r         <= '0;
      vcnt_r        <= '0;
      prod_r        <= '0;
      scale_r       <= SCALE_RESET;
      thresh_r      <= THRESH_RESET;
      out_valid_r   <= 1'b0;
      out_volt_r    <= '0;
      out_mean_r    <= '0;
      out_avg_r     <= '0;
      out_press_r   <= '0;
      out_held_r    <= 1'b0;
      out_isp_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      burst_sum_r   <= burst_sum_nxt;
      burst_cnt_r   <= burst_cnt_nxt;
      ring_pos_r    <= ring_pos_nxt;
      walk_idx_r    <= walk_idx_nxt;
      press_r       <= press_nxt;
      stored_volt_r <= stored_volt_nxt;
      stored_mean_r <= stored_mean_nxt;
      avg_r         <= avg_nxt;
      is_press_r    <= is_press_nxt;
      empty_r       <= empty_nxt;
      acc_pend_r    <= ring_rd_en;
      tot_r         <= tot_nxt;
      vcnt_r        <= vcnt_nxt;
      prod_r        <= prod_nxt;
      scale_r       <= scale_nxt;
      thresh_r      <= thresh_nxt;
      out_valid_r   <= out_valid_nxt;
      out_volt_r    <= out_volt_nxt;
      out_mean_r    <= out_mean_nxt;
      out_avg_r     <= out_avg_nxt;
      out_press_r   <= out_press_nxt;
      out_held_r    <= out_held_nxt;
      out_isp_r     <= out_isp_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_voltage_mv   = out_volt_r;
  assign out_pin_mean     = out_mean_r;
  assign out_poll_average = out_avg_r;
  assign out_press_count  = out_press_r;
  assign out_button_held  = out_held_r;
  assign out_is_press     = out_isp_r;

  // checks
  `CHK_IMPLY(a_div_idle, div_start, !div_stat.busy, "divider started while busy")
  `CHK_NEXT(a_ring_adv, ring_wr_en, ring_pos_r != $past(ring_pos_r), "ring position stuck")
  `CHK_IMPLY(a_press_cnt, out_valid_r && out_isp_r, out_press_r != '0, "press word, zero count")
  `CHK_IMPLY(a_nopress, out_valid_r && !out_isp_r, (out_press_r == '0) && !out_held_r, "count not cleared")

endmodule
